// File: rtl/tslc_pkg.sv
package tslc_pkg;

   localparam int unsigned DEFAULT_SEGMENT_ENTRIES = 256;
   localparam int unsigned DEFAULT_KEY_BITS = 64;

   localparam int unsigned REQ_DATA_BITS = 128;
   localparam int unsigned RSP_DATA_BITS = 104;
   localparam int unsigned CSR_DATA_BITS = 32;
   localparam int unsigned SUM_BITS = 48;

   localparam logic CSR_PROBATION_CAP = 1'b0;
   localparam logic CSR_PROTECTED_CAP = 1'b1;

   localparam logic [1:0] SEG_NONE = 2'd0;
   localparam logic [1:0] SEG_PROTECTED = 2'd1;
   localparam logic [1:0] SEG_PROBATION = 2'd2;

   localparam logic [31:0] CAP_RESET = 32'd29360128;

   typedef enum logic [1:0] {
      SCAN_LOOKUP,
      SCAN_VICTIM,
      SCAN_FREE
   } scan_mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOOK_PROT,
      ST_LOOK_PROB,
      ST_CHECK_PROB,
      ST_VIC_PROB,
      ST_CHECK_PROT,
      ST_VIC_PROT,
      ST_FREE_PROT,
      ST_FREE_PROB,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic          load;
      logic          scan_start;
      logic          scan_prot;
      scan_mode_type scan_mode;
      logic          hit_touch;
      logic          evict;
      logic          insert_new;
      logic          insert_demoted;
      logic          finish;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic found;
      logic prob_evict_need;
      logic prot_evict_need;
      logic new_too_big;
      logic victim_too_big;
   } status_type;

endpackage

// File: rtl/two_segment_lru_byte_cache_core.sv
// two-segment size-aware lru byte cache
// req channel: one request per object access, tdata = key, size, timestamp.
// rsp channel: exactly one response per request, in request order, with hit
// flag, hit segment and the running total and hit byte counters.
// csr port: csr_we with csr_index 0 writes the probation capacity, 1 the
// protected capacity; write only while no request is in flight.
// each request takes one key lookup scan of the protected segment and, on a
// protected miss, one of probation. a stored miss adds one scan per probation
// victim, per protected victim and per free-slot search. the scans read the
// entry memories, each with one read and one write port, one entry a cycle.
// a new request is taken only after the last one finished; the response waits
// in an output register, and while the receiver stalls the next request is
// still processed up to the point of reporting.
// reset (synchronous) clears all valid bits, byte counters and usage, and
// restores both capacities to their reset value; no clearing pass is needed.
module two_segment_lru_byte_cache_core
   import tslc_pkg::*;
#(
   parameter int unsigned SEGMENT_ENTRIES = DEFAULT_SEGMENT_ENTRIES,
   parameter int unsigned KEY_BITS = DEFAULT_KEY_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // object_key[63:0], object_size[95:64], access_time[127:96]
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // hit[0], hit_segment[2:1], total_bytes[50:3], hit_bytes_total[98:51], zero pad
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                     csr_we,
   input  logic                     csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   cmd_type cmd;
   status_type status;

   tslc_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   tslc_datapath #(
      .SEGMENT_ENTRIES (SEGMENT_ENTRIES),
      .KEY_BITS        (KEY_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// File: rtl/tslc_datapath.sv
module tslc_datapath
   import tslc_pkg::*;
#(
   parameter int unsigned SEGMENT_ENTRIES = DEFAULT_SEGMENT_ENTRIES,
   parameter int unsigned KEY_BITS = DEFAULT_KEY_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output status_type               status,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  logic                     csr_we,
   input  logic                     csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   localparam int unsigned IW = $clog2(SEGMENT_ENTRIES);
   localparam int unsigned CW = $clog2(SEGMENT_ENTRIES + 1);
   localparam logic [CW-1:0] FULL = CW'(SEGMENT_ENTRIES);

   logic [31:0] prob_cap_ff, prot_cap_ff;
   logic [KEY_BITS-1:0] req_key_ff;
   logic [31:0] req_size_ff, req_time_ff;
   logic [SUM_BITS-1:0] total_ff, hit_sum_ff;
   logic [1:0] hit_seg_ff;

   logic prob_vld_ff [SEGMENT_ENTRIES];
   logic prot_vld_ff [SEGMENT_ENTRIES];
   logic [CW-1:0] prob_cnt_ff, prot_cnt_ff;
   logic [32:0] prob_used_ff, prot_used_ff;

   logic [KEY_BITS-1:0] prob_key_mem [SEGMENT_ENTRIES];
   logic [31:0] prob_size_mem [SEGMENT_ENTRIES];
   logic [31:0] prob_time_mem [SEGMENT_ENTRIES];
   logic [KEY_BITS-1:0] prot_key_mem [SEGMENT_ENTRIES];
   logic [31:0] prot_size_mem [SEGMENT_ENTRIES];
   logic [31:0] prot_time_mem [SEGMENT_ENTRIES];
   logic [KEY_BITS-1:0] prob_rd_key_ff, prot_rd_key_ff;
   logic [31:0] prob_rd_size_ff, prot_rd_size_ff, prob_rd_time_ff, prot_rd_time_ff;

   // scan engine
   logic scan_act_ff, scan_prot_ff;
   scan_mode_type scan_mode_ff;
   logic [CW-1:0] ptr_ff;
   logic s1_vld_ff, s1_valid_ff;
   logic [IW-1:0] s1_idx_ff;
   logic res_found_ff;
   logic [IW-1:0] res_idx_ff;
   logic [KEY_BITS-1:0] res_key_ff;
   logic [31:0] res_size_ff, res_time_ff;

   logic [KEY_BITS-1:0] dem_key_ff;
   logic [31:0] dem_size_ff, dem_time_ff;

   logic issue;
   logic [IW-1:0] rd_addr;
   logic [KEY_BITS-1:0] cur_key;
   logic [31:0] cur_size, cur_time;
   logic better, take;
   logic [SUM_BITS-1:0] hit_sum_in;

   assign issue = scan_act_ff && (ptr_ff < FULL);
   assign rd_addr = ptr_ff[IW-1:0];

   assign cur_key = scan_prot_ff ? prot_rd_key_ff : prob_rd_key_ff;
   assign cur_size = scan_prot_ff ? prot_rd_size_ff : prob_rd_size_ff;
   assign cur_time = scan_prot_ff ? prot_rd_time_ff : prob_rd_time_ff;

   // oldest stamp, then largest size, then lowest key
   assign better = (cur_time < res_time_ff) ||
                   ((cur_time == res_time_ff) && ((cur_size > res_size_ff) ||
                   ((cur_size == res_size_ff) && (cur_key < res_key_ff))));

   always_comb begin
      take = 1'b0;
      case (scan_mode_ff)
         SCAN_LOOKUP: take = s1_valid_ff && (cur_key == req_key_ff) && !res_found_ff;
         SCAN_VICTIM: take = s1_valid_ff && (!res_found_ff || better);
         SCAN_FREE:   take = !s1_valid_ff && !res_found_ff;
         default:     take = 1'b0;
      endcase
      take = take && s1_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_act_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
      end else if (cmd.scan_start) begin
         scan_act_ff <= 1'b1;
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= issue;
         if (scan_act_ff && !issue && !s1_vld_ff) begin
            scan_act_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         ptr_ff <= '0;
         scan_prot_ff <= cmd.scan_prot;
         scan_mode_ff <= cmd.scan_mode;
         res_found_ff <= 1'b0;
      end else begin
         if (issue) begin
            ptr_ff <= ptr_ff + CW'(1);
         end
         if (take) begin
            res_found_ff <= 1'b1;
            res_idx_ff <= s1_idx_ff;
            res_key_ff <= cur_key;
            res_size_ff <= cur_size;
            res_time_ff <= cur_time;
         end
      end
      s1_idx_ff <= rd_addr;
      s1_valid_ff <= scan_prot_ff ? prot_vld_ff[rd_addr] : prob_vld_ff[rd_addr];
   end

   // memories
   always_ff @(posedge clock) begin
      if (cmd.insert_new) begin
         prob_key_mem[res_idx_ff] <= req_key_ff;
         prob_size_mem[res_idx_ff] <= req_size_ff;
      end
      if (cmd.insert_new || (cmd.hit_touch && !scan_prot_ff)) begin
         prob_time_mem[res_idx_ff] <= req_time_ff;
      end
      prob_rd_key_ff <= prob_key_mem[rd_addr];
      prob_rd_size_ff <= prob_size_mem[rd_addr];
      prob_rd_time_ff <= prob_time_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.insert_demoted) begin
         prot_key_mem[res_idx_ff] <= dem_key_ff;
         prot_size_mem[res_idx_ff] <= dem_size_ff;
      end
      if (cmd.insert_demoted || (cmd.hit_touch && scan_prot_ff)) begin
         prot_time_mem[res_idx_ff] <= cmd.insert_demoted ? dem_time_ff : req_time_ff;
      end
      prot_rd_key_ff <= prot_key_mem[rd_addr];
      prot_rd_size_ff <= prot_size_mem[rd_addr];
      prot_rd_time_ff <= prot_time_mem[rd_addr];
   end

   // occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SEGMENT_ENTRIES; i++) begin
            prob_vld_ff[i] <= 1'b0;
            prot_vld_ff[i] <= 1'b0;
         end
         prob_cnt_ff <= '0;
         prot_cnt_ff <= '0;
         prob_used_ff <= '0;
         prot_used_ff <= '0;
      end else begin
         if (cmd.evict && res_found_ff) begin
            if (scan_prot_ff) begin
               prot_vld_ff[res_idx_ff] <= 1'b0;
               prot_cnt_ff <= prot_cnt_ff - CW'(1);
               prot_used_ff <= prot_used_ff - {1'b0, res_size_ff};
            end else begin
               prob_vld_ff[res_idx_ff] <= 1'b0;
               prob_cnt_ff <= prob_cnt_ff - CW'(1);
               prob_used_ff <= prob_used_ff - {1'b0, res_size_ff};
            end
         end
         if (cmd.insert_new && res_found_ff) begin
            prob_vld_ff[res_idx_ff] <= 1'b1;
            prob_cnt_ff <= prob_cnt_ff + CW'(1);
            prob_used_ff <= prob_used_ff + {1'b0, req_size_ff};
         end
         if (cmd.insert_demoted && res_found_ff) begin
            prot_vld_ff[res_idx_ff] <= 1'b1;
            prot_cnt_ff <= prot_cnt_ff + CW'(1);
            prot_used_ff <= prot_used_ff + {1'b0, dem_size_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.evict && !scan_prot_ff) begin
         dem_key_ff <= res_key_ff;
         dem_size_ff <= res_size_ff;
         dem_time_ff <= res_time_ff;
      end
   end

   // request capture, counters, capacities
   assign hit_sum_in = hit_sum_ff + ((hit_seg_ff != SEG_NONE) ?
                       {16'd0, req_size_ff} : {SUM_BITS{1'b0}});

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_key_ff <= req_tdata[KEY_BITS-1:0];
         req_size_ff <= req_tdata[95:64];
         req_time_ff <= req_tdata[127:96];
      end
      if (cmd.finish) begin
         rsp_tdata <= {5'd0, hit_sum_in, total_ff, hit_seg_ff, hit_seg_ff != SEG_NONE};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         hit_sum_ff <= '0;
         hit_seg_ff <= SEG_NONE;
         prob_cap_ff <= CAP_RESET;
         prot_cap_ff <= CAP_RESET;
      end else begin
         if (cmd.load) begin
            total_ff <= total_ff + {16'd0, req_tdata[95:64]};
            hit_seg_ff <= SEG_NONE;
         end
         if (cmd.hit_touch) begin
            hit_seg_ff <= scan_prot_ff ? SEG_PROTECTED : SEG_PROBATION;
         end
         if (cmd.finish) begin
            hit_sum_ff <= hit_sum_in;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_PROBATION_CAP: prob_cap_ff <= csr_wdata;
               CSR_PROTECTED_CAP: prot_cap_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   assign status.scan_done = scan_act_ff && !issue && !s1_vld_ff;
   assign status.found = res_found_ff;
   assign status.prob_evict_need = (prob_cnt_ff != '0) &&
      ((({1'b0, prob_used_ff} + {2'b0, req_size_ff}) > {2'b0, prob_cap_ff}) ||
       (prob_cnt_ff == FULL));
   assign status.prot_evict_need = (prot_cnt_ff != '0) &&
      ((({1'b0, prot_used_ff} + {2'b0, dem_size_ff}) > {2'b0, prot_cap_ff}) ||
       (prot_cnt_ff == FULL));
   assign status.new_too_big = req_size_ff >= prob_cap_ff;
   assign status.victim_too_big = res_size_ff >= prot_cap_ff;

   a_prob_cnt: assert property (@(posedge clock) disable iff (reset)
      prob_cnt_ff <= FULL && prot_cnt_ff <= FULL)
      else $error("segment entry count beyond table size");
   a_scan_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_start |-> (!scan_act_ff || status.scan_done))
      else $error("scan started while another scan runs");
   a_evict_found: assert property (@(posedge clock) disable iff (reset)
      cmd.evict |-> res_found_ff)
      else $error("eviction without a victim");

endmodule

// File: rtl/tslc_control.sv
module tslc_control
   import tslc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output cmd_type    cmd,
   input  status_type status
);

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_valid_in = cmd.finish || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_tvalid) state_in = ST_LOOK_PROT;
         ST_LOOK_PROT: begin
            if (status.scan_done) state_in = status.found ? ST_FINISH : ST_LOOK_PROB;
         end
         ST_LOOK_PROB: begin
            if (status.scan_done) begin
               if (status.found || status.new_too_big) state_in = ST_FINISH;
               else state_in = ST_CHECK_PROB;
            end
         end
         ST_CHECK_PROB: state_in = status.prob_evict_need ? ST_VIC_PROB : ST_FREE_PROB;
         ST_VIC_PROB: begin
            if (status.scan_done) begin
               state_in = status.victim_too_big ? ST_CHECK_PROB : ST_CHECK_PROT;
            end
         end
         ST_CHECK_PROT: state_in = status.prot_evict_need ? ST_VIC_PROT : ST_FREE_PROT;
         ST_VIC_PROT: if (status.scan_done) state_in = ST_CHECK_PROT;
         ST_FREE_PROT: if (status.scan_done) state_in = ST_CHECK_PROB;
         ST_FREE_PROB: if (status.scan_done) state_in = ST_FINISH;
         ST_FINISH: if (rsp_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.scan_mode = SCAN_LOOKUP;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               cmd.scan_start = 1'b1;
               cmd.scan_prot = 1'b1;
            end
         end
         ST_LOOK_PROT: begin
            if (status.scan_done) begin
               cmd.hit_touch = status.found;
               cmd.scan_start = !status.found;
            end
         end
         ST_LOOK_PROB: begin
            if (status.scan_done) cmd.hit_touch = status.found;
         end
         ST_CHECK_PROB: begin
            cmd.scan_start = 1'b1;
            cmd.scan_mode = status.prob_evict_need ? SCAN_VICTIM : SCAN_FREE;
         end
         ST_VIC_PROB, ST_VIC_PROT: cmd.evict = status.scan_done;
         ST_CHECK_PROT: begin
            cmd.scan_start = 1'b1;
            cmd.scan_prot = 1'b1;
            cmd.scan_mode = status.prot_evict_need ? SCAN_VICTIM : SCAN_FREE;
         end
         ST_FREE_PROT: cmd.insert_demoted = status.scan_done;
         ST_FREE_PROB: cmd.insert_new = status.scan_done;
         ST_FINISH: cmd.finish = rsp_free;
         default: ;
      endcase
   end

   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_tvalid)
      else $error("finished request not presented");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !cmd.finish)
      else $error("pending response overwritten");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_LOOK_PROT))
      else $error("request load outside idle");

endmodule

// File: tb/sv/tb_top.sv
module tb_top
   import tslc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_ENTRIES = 256;
   localparam int PROB = 0;
   localparam int PROT = 1;
   localparam int IDLE_LIMIT = 4000000;
   localparam int LONG_HOLD = 3000;

   typedef struct {
      logic        hit;
      logic [1:0]  seg;
      logic [47:0] total;
      logic [47:0] hit_total;
   } cache_resp_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic csr_we;
   logic csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   two_segment_lru_byte_cache_core DUT (.*);

   // cache image kept by the testbench, index 0 probation, 1 protected
   bit          line_valid[2][N_ENTRIES];
   logic [63:0] line_key[2][N_ENTRIES];
   longint unsigned line_size[2][N_ENTRIES];
   logic [31:0] line_stamp[2][N_ENTRIES];
   longint unsigned seg_used[2];
   longint unsigned seg_cap[2];
   logic [47:0] byte_sum;
   logic [47:0] hit_sum;

   cache_resp_type pending_resp[$];
   int errors;
   int idle_cycles;
   bit hold_rsp;
   bit no_gaps;
   logic [31:0] clock_stamp;
   logic [63:0] key_pool[40];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int find_key(int s, logic [63:0] key);
      for (int i = 0; i < N_ENTRIES; i++)
         if (line_valid[s][i] && line_key[s][i] == key) return i;
      return -1;
   endfunction

   function automatic int count_lines(int s);
      int n;
      n = 0;
      for (int i = 0; i < N_ENTRIES; i++) if (line_valid[s][i]) n++;
      return n;
   endfunction

   function automatic int free_line(int s);
      for (int i = 0; i < N_ENTRIES; i++) if (!line_valid[s][i]) return i;
      return -1;
   endfunction

   // oldest stamp, then largest size, then lowest key
   function automatic int pick_victim(int s);
      int best;
      best = -1;
      for (int i = 0; i < N_ENTRIES; i++) begin
         if (!line_valid[s][i]) continue;
         if (best < 0) best = i;
         else if (line_stamp[s][i] < line_stamp[s][best] ||
                  (line_stamp[s][i] == line_stamp[s][best] &&
                   (line_size[s][i] > line_size[s][best] ||
                    (line_size[s][i] == line_size[s][best] &&
                     line_key[s][i] < line_key[s][best]))))
            best = i;
      end
      return best;
   endfunction

   function automatic void place_line(int s, logic [63:0] key, longint unsigned sz,
                                      logic [31:0] ts);
      int slot;
      slot = free_line(s);
      if (slot < 0) return;
      line_valid[s][slot] = 1;
      line_key[s][slot] = key;
      line_size[s][slot] = sz;
      line_stamp[s][slot] = ts;
      seg_used[s] += sz;
   endfunction

   function automatic void demote_oldest();
      int v, n;
      logic [63:0] key;
      longint unsigned sz;
      logic [31:0] ts;
      v = pick_victim(PROB);
      if (v < 0) return;
      key = line_key[PROB][v];
      sz = line_size[PROB][v];
      ts = line_stamp[PROB][v];
      line_valid[PROB][v] = 0;
      seg_used[PROB] -= sz;
      if (sz >= seg_cap[PROT]) return;
      n = count_lines(PROT);
      while (n > 0 && (seg_used[PROT] + sz > seg_cap[PROT] || n >= N_ENTRIES)) begin
         v = pick_victim(PROT);
         line_valid[PROT][v] = 0;
         seg_used[PROT] -= line_size[PROT][v];
         n = count_lines(PROT);
      end
      place_line(PROT, key, sz, ts);
   endfunction

   function automatic cache_resp_type access_cache(logic [63:0] key, logic [31:0] size,
                                                   logic [31:0] ts);
      cache_resp_type r;
      int idx, n;
      longint unsigned sz;
      sz = size;
      r.hit = 0;
      r.seg = SEG_NONE;
      byte_sum += 48'(size);
      idx = find_key(PROT, key);
      if (idx >= 0) begin
         line_stamp[PROT][idx] = ts;
         r.hit = 1;
         r.seg = SEG_PROTECTED;
      end else begin
         idx = find_key(PROB, key);
         if (idx >= 0) begin
            line_stamp[PROB][idx] = ts;
            r.hit = 1;
            r.seg = SEG_PROBATION;
         end else if (sz < seg_cap[PROB]) begin
            n = count_lines(PROB);
            while (n > 0 && (seg_used[PROB] + sz > seg_cap[PROB] || n >= N_ENTRIES)) begin
               demote_oldest();
               n = count_lines(PROB);
            end
            place_line(PROB, key, sz, ts);
         end
      end
      if (r.hit) hit_sum += 48'(size);
      r.total = byte_sum;
      r.hit_total = hit_sum;
      return r;
   endfunction

   // starts and ends on a falling edge
   task automatic send_request(logic [63:0] key, logic [31:0] size, logic [31:0] ts);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {ts, size, key};
      do @(posedge clock); while (!req_tready);
      pending_resp.push_back(access_cache(key, size, ts));
      @(negedge clock);
   endtask

   task automatic write_reg(logic idx, logic [31:0] value);
      req_tvalid <= 1'b0;
      wait (pending_resp.size() == 0);
      repeat (8) @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      seg_cap[idx == CSR_PROBATION_CAP ? PROB : PROT] = value;
   endtask

   task automatic test_directed();
      write_reg(CSR_PROBATION_CAP, 32'd1000);
      write_reg(CSR_PROTECTED_CAP, 32'd500);
      send_request(64'd1, 32'd100, 32'd10);      // miss into probation
      send_request(64'd1, 32'd100, 32'd11);      // probation hit
      send_request(64'd2, 32'd950, 32'd12);      // demotes key 1 to protected
      send_request(64'd1, 32'd7, 32'd13);        // protected hit
      send_request(64'd3, 32'd600, 32'd14);      // victim too big for protected
      send_request(64'd4, 32'd1000, 32'd15);     // object equal to capacity
      send_request(64'd5, 32'hFFFF_FFFF, 32'd16);
      send_request(64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
      send_request(64'd0, 32'd0, 32'd0);
      send_request(64'd6, 32'd300, 32'd0);       // stamp ties, size and key decide
      send_request(64'd7, 32'd300, 32'd0);
      send_request(64'd8, 32'd300, 32'd0);
      send_request(64'd0, 32'd5, 32'd20);
      send_request(64'hFFFF_FFFF_FFFF_FFFF, 32'd5, 32'd21);
      // lowered capacity: repeated eviction until the object fits
      write_reg(CSR_PROBATION_CAP, 32'd50);
      send_request(64'd9, 32'd40, 32'd22);
      send_request(64'd10, 32'd49, 32'd23);
      write_reg(CSR_PROBATION_CAP, 32'd0);
      send_request(64'd11, 32'd0, 32'd24);
      write_reg(CSR_PROTECTED_CAP, 32'd0);
      write_reg(CSR_PROBATION_CAP, 32'hFFFF_FFFF);
      send_request(64'd12, 32'hFFFF_FFFE, 32'd25);
      send_request(64'd13, 32'd1, 32'd26);
      write_reg(CSR_PROTECTED_CAP, 32'hFFFF_FFFF);
      send_request(64'd14, 32'hFFFF_FFFE, 32'd27);
   endtask

   // more distinct keys than table lines, so probation evicts on count
   task automatic test_full_table();
      no_gaps = 1;
      for (int i = 0; i < 262; i++)
         send_request({32'hA5A5_0000, 32'(i)}, 32'd1 + 32'(i % 3), 32'd100 + 32'(i / 2));
      no_gaps = 0;
      for (int i = 0; i < 6; i++)
         send_request({32'hA5A5_0000, 32'(i * 40)}, 32'd1, 32'd2000);
   endtask

   task automatic test_backpressure();
      hold_rsp = 1;
      no_gaps = 1;
      for (int i = 0; i < 12; i++)
         send_request(key_pool[i], $urandom_range(0, 3000), clock_stamp + 32'(i));
      no_gaps = 0;
   endtask

   task automatic test_random(int items, int size_limit);
      logic [63:0] key;
      logic [31:0] size;
      for (int i = 0; i < items; i++) begin
         key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                           : key_pool[$urandom_range(0, 39)];
         size = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, size_limit);
         if ($urandom_range(0, 20) == 0) clock_stamp = $urandom;
         else clock_stamp += $urandom_range(0, 3);
         send_request(key, size, clock_stamp);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = CSR_PROBATION_CAP;
      csr_wdata = '0;
      errors = 0;
      hold_rsp = 0;
      no_gaps = 0;
      clock_stamp = 32'd5000;
      byte_sum = '0;
      hit_sum = '0;
      seg_used = '{0, 0};
      seg_cap = '{CAP_RESET, CAP_RESET};
      foreach (line_valid[s, i]) line_valid[s][i] = 0;
      foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_random(30, 3000000);                  // reset capacities first
      test_directed();
      test_full_table();
      write_reg(CSR_PROBATION_CAP, 32'd20000);
      write_reg(CSR_PROTECTED_CAP, 32'd12000);
      test_backpressure();
      test_random(90, 4000);
      write_reg(CSR_PROBATION_CAP, 32'hFFFF_FFFF);
      write_reg(CSR_PROTECTED_CAP, 32'd3000);
      test_random(60, 5000);
      write_reg(CSR_PROBATION_CAP, 32'd0);
      test_random(20, 100);
      write_reg(CSR_PROBATION_CAP, 32'd9000);
      write_reg(CSR_PROTECTED_CAP, 32'hFFFF_FFFF);
      test_random(90, 3000);
      req_tvalid <= 1'b0;
      wait (pending_resp.size() == 0);
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // response side: random hold-offs, one long one on request
   initial begin
      int n;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_rsp = 0;
         end
         n = no_gaps ? 0 : $urandom_range(0, 5);
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      cache_resp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_resp.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response %h", rsp_tdata);
         end else begin
            want = pending_resp.pop_front();
            if (rsp_tdata[0] !== want.hit || rsp_tdata[2:1] !== want.seg ||
                rsp_tdata[50:3] !== want.total || rsp_tdata[98:51] !== want.hit_total) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: exp hit %0d seg %0d total %0d hits %0d, got %0d %0d %0d %0d",
                           want.hit, want.seg, want.total, want.hit_total,
                           rsp_tdata[0], rsp_tdata[2:1], rsp_tdata[50:3], rsp_tdata[98:51]);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

endmodule
